FILE: hdl/tra_pkg.sv
// Package for the tanh rational approximation block.
// Holds the item type passed from front to back, field widths and polynomial constants.
// No dependencies.
package tra_pkg;

  localparam int X_W    = 16;  // Q4.12 input sample
  localparam int Y_W    = 16;  // Q1.14 result
  localparam int MAG_W  = 15;  // magnitude of an unsaturated sample, at most 5.0
  localparam int T_W    = 17;  // x^2 in Q.12, at most 102400
  localparam int P1_W   = 21;
  localparam int P2_W   = 27;
  localparam int P3_W   = 32;
  localparam int Q1_W   = 24;
  localparam int Q2_W   = 30;
  localparam int Q3_W   = 35;
  localparam int NUM_W  = MAG_W + P3_W;  // |x| * P
  localparam int D_W    = NUM_W + 2;     // |x| * P * 4
  localparam int QUO_W  = 20;            // quotient bits, quotient stays below 2^20
  localparam int REM_W  = Q3_W;
  localparam int FIFO_DEPTH = 2;

  localparam logic signed [X_W-1:0] FIVE_Q12 = 16'sd20480;
  localparam logic [MAG_W-1:0]      ONE_Q14  = 15'd16384;

  localparam logic [P1_W-1:0] P_C3 = 21'(378 * 4096);
  localparam logic [P2_W-1:0] P_C2 = 27'(17325 * 4096);
  localparam logic [P3_W-1:0] P_C1 = 32'(135135 * 4096);
  localparam logic [Q1_W-1:0] Q_C3 = 24'(3150 * 4096);
  localparam logic [Q2_W-1:0] Q_C2 = 30'(62370 * 4096);
  localparam logic [Q3_W-1:0] Q_C1 = 35'(135135 * 4096);
  localparam logic [Q1_W-1:0] Q_T3 = 24'd28;

  // One classified word on its way from the front to the back.
  typedef struct packed {
    logic             neg;
    logic             sat;
    logic [MAG_W-1:0] mag;
  } item_t;

endpackage

FILE: hdl/tra_front.sv
// Front end of the tanh block: accepts a sample and classifies it.
// Depends on tra_pkg.
module tra_front import tra_pkg::*; (
  input  logic                  start,
  input  logic                  full,
  input  logic signed [X_W-1:0] x_in,
  output logic                  busy,
  output logic                  push,
  output item_t                 item
);

  logic [X_W-1:0] abs_x;

  assign busy  = full;
  assign push  = start && !full;
  assign abs_x = x_in[X_W-1] ? X_W'(-x_in) : x_in;

  // Saturation covers x > 5.0 and x <= -5.0; everything else has |x| <= 5.0.
  always_comb begin
    item.neg = x_in[X_W-1];
    item.sat = (x_in > FIVE_Q12) || (x_in <= -FIVE_Q12);
    item.mag = item.sat ? MAG_W'(0) : abs_x[MAG_W-1:0];
  end

endmodule

FILE: hdl/tra_fifo.sv
// Short queue of classified words between the front and the back.
// Depends on tra_pkg.
module tra_fifo import tra_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t wdata,
  input  logic  pop,
  output logic  full,
  output logic  empty,
  output item_t rdata
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  item_t            mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_pop;

  assign full   = (cnt_r == CNT_W'(FIFO_DEPTH));
  assign empty  = (cnt_r == '0);
  assign do_pop = pop && !empty;
  assign rdata  = mem[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= (wp_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (do_pop) rp_r <= (rp_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wdata;
  end

endmodule

FILE: hdl/tra_back.sv
// Back end of the tanh block: Horner polynomials and a pipelined restoring divider.
// Depends on tra_pkg.
module tra_back import tra_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  item_t            item,
  output logic             out_vld,
  output logic [Y_W-1:0]   out_y
);

  // Stage 0: x^2.
  logic             v0_r, neg0_r, sat0_r;
  logic [MAG_W-1:0] mag0_r;
  logic [T_W-1:0]   t0_r;
  // Stage 1: polynomial seeds.
  logic             v1_r, neg1_r, sat1_r;
  logic [MAG_W-1:0] mag1_r;
  logic [T_W-1:0]   t1_r;
  logic [P1_W-1:0]  p1_r;
  logic [Q1_W-1:0]  q1_r;
  // Stage 2 and 3: Horner steps.
  logic             v2_r, neg2_r, sat2_r;
  logic [MAG_W-1:0] mag2_r;
  logic [T_W-1:0]   t2_r;
  logic [P2_W-1:0]  p2_r;
  logic [Q2_W-1:0]  q2_r;
  logic             v3_r, neg3_r, sat3_r;
  logic [MAG_W-1:0] mag3_r;
  logic [P3_W-1:0]  p3_r;
  logic [Q3_W-1:0]  q3_r;
  // Stage 4: numerator.
  logic             v4_r, neg4_r, sat4_r;
  logic [NUM_W-1:0] num4_r;
  logic [Q3_W-1:0]  q4_r;

  logic [2*MAG_W-1:0]     sq;
  logic [T_W+P1_W-1:0]    tp1;
  logic [T_W+Q1_W-1:0]    tq1;
  logic [T_W+P2_W-1:0]    tp2;
  logic [T_W+Q2_W-1:0]    tq2;
  logic [D_W-1:0]         dvd;

  // Divider pipeline, one quotient bit per stage.
  logic             dv_r   [QUO_W+1];
  logic             dneg_r [QUO_W+1];
  logic             dsat_r [QUO_W+1];
  logic [REM_W-1:0] rem_r  [QUO_W+1];
  logic [QUO_W-1:0] low_r  [QUO_W+1];
  logic [QUO_W-1:0] quo_r  [QUO_W+1];
  logic [Q3_W-1:0]  dq_r   [QUO_W+1];
  logic [REM_W:0]   sh     [QUO_W];
  logic             ge     [QUO_W];

  logic [QUO_W-1:0] qf;
  logic [MAG_W-1:0] mag_f;
  logic             ov_r;
  logic [Y_W-1:0]   y_r;

  assign sq  = item.mag * item.mag;
  assign tp1 = t1_r * p1_r;
  assign tq1 = t1_r * q1_r;
  assign tp2 = t2_r * p2_r;
  assign tq2 = t2_r * q2_r;
  assign dvd = {num4_r, 2'b00};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v0_r <= in_vld;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    neg0_r <= item.neg;
    sat0_r <= item.sat;
    mag0_r <= item.mag;
    t0_r   <= sq[T_W+11:12];

    neg1_r <= neg0_r;
    sat1_r <= sat0_r;
    mag1_r <= mag0_r;
    t1_r   <= t0_r;
    p1_r   <= P_C3 + P1_W'(t0_r);
    q1_r   <= Q_C3 + Q_T3 * Q1_W'(t0_r);

    neg2_r <= neg1_r;
    sat2_r <= sat1_r;
    mag2_r <= mag1_r;
    t2_r   <= t1_r;
    p2_r   <= P_C2 + P2_W'(tp1 >> 12);
    q2_r   <= Q_C2 + Q2_W'(tq1 >> 12);

    neg3_r <= neg2_r;
    sat3_r <= sat2_r;
    mag3_r <= mag2_r;
    p3_r   <= P_C1 + P3_W'(tp2 >> 12);
    q3_r   <= Q_C1 + Q3_W'(tq2 >> 12);

    neg4_r <= neg3_r;
    sat4_r <= sat3_r;
    num4_r <= mag3_r * p3_r;
    q4_r   <= q3_r;
  end

  always_comb begin
    for (int k = 0; k < QUO_W; k++) begin
      sh[k] = {rem_r[k], low_r[k][QUO_W-1]};
      ge[k] = (sh[k] >= {1'b0, dq_r[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QUO_W; k++) dv_r[k] <= 1'b0;
    end else begin
      dv_r[0] <= v4_r;
      for (int k = 0; k < QUO_W; k++) dv_r[k+1] <= dv_r[k];
    end
  end

  // The quotient stays below 2^QUO_W, so the top bits of the dividend start out below Q.
  always_ff @(posedge clk) begin
    dneg_r[0] <= neg4_r;
    dsat_r[0] <= sat4_r;
    rem_r[0]  <= REM_W'(dvd[D_W-1:QUO_W]);
    low_r[0]  <= dvd[QUO_W-1:0];
    quo_r[0]  <= '0;
    dq_r[0]   <= q4_r;
    for (int k = 0; k < QUO_W; k++) begin
      dneg_r[k+1] <= dneg_r[k];
      dsat_r[k+1] <= dsat_r[k];
      dq_r[k+1]   <= dq_r[k];
      low_r[k+1]  <= {low_r[k][QUO_W-2:0], 1'b0};
      quo_r[k+1]  <= {quo_r[k][QUO_W-2:0], ge[k]};
      rem_r[k+1]  <= ge[k] ? REM_W'(sh[k] - {1'b0, dq_r[k]}) : sh[k][REM_W-1:0];
    end
  end

  always_comb begin
    qf = quo_r[QUO_W];
    if (dsat_r[QUO_W] || qf > QUO_W'(ONE_Q14)) mag_f = ONE_Q14;
    else mag_f = qf[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else ov_r <= dv_r[QUO_W];
  end

  always_ff @(posedge clk) begin
    y_r <= dneg_r[QUO_W] ? Y_W'(-{1'b0, mag_f}) : {1'b0, mag_f};
  end

  assign out_vld = ov_r;
  assign out_y   = y_r;

endmodule

FILE: hdl/tanh_rational_approx.sv
// Top level of the tanh rational approximation block.
// Depends on tra_pkg, tra_front, tra_fifo and tra_back.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------
//   input    | start / busy       | in_x_in      (Q4.12 signed)
//   result   | out_valid (strobe) | out_tanh_out (Q1.14 signed)
//
// One word is accepted per cycle when start is high and busy is low; the
// back end never stalls, so busy stays low in practice and one result leaves
// per cycle. Each accepted word passes through the queue, the five
// polynomial stages, the 20-stage divider that produces one quotient bit per
// stage and the output register. Reset is synchronous and active low and
// clears only the queue pointers and count and the valid bits. The receiver
// cannot stall: a result is on the ports for exactly one cycle.
module tanh_rational_approx import tra_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [X_W-1:0] in_x_in,
  output logic                  out_valid,
  output logic signed [Y_W-1:0] out_tanh_out
);

  localparam int LATENCY = 8 + QUO_W;

  item_t          front_item, head_item;
  logic           push, full, empty;
  logic [Y_W-1:0] y;

  // The front classifies each word into saturated or computed and its sign.
  tra_front u_front (
    .start (start),
    .full  (full),
    .x_in  (in_x_in),
    .busy  (busy),
    .push  (push),
    .item  (front_item)
  );

  // The queue decouples acceptance from the arithmetic pipeline.
  tra_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (front_item),
    .pop   (1'b1),
    .full  (full),
    .empty (empty),
    .rdata (head_item)
  );

  // The back pops a word every cycle the queue holds one.
  tra_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (!empty),
    .item    (head_item),
    .out_vld (out_valid),
    .out_y   (y)
  );

  assign out_tanh_out = signed'(y);

  // Every accepted word yields its result a fixed number of cycles later.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LATENCY out_valid)
    else $error("result missing after accepted word");

  // Results never exceed one in magnitude.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tanh_out <= 16'sd16384) && (out_tanh_out >= -16'sd16384))
    else $error("result out of range");

  // The queue never fills because the back drains it every cycle.
  a_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("queue filled unexpectedly");

endmodule
